/* rtl/rmvs_pkg.sv */
// ----------------------------------------------------------------------------
// rmvs_pkg: shared types and constants of the running statistics unit
// Field widths, register indexes and the sequencer state encoding.
// ----------------------------------------------------------------------------
package rmvs_pkg;

  localparam int SAMPLE_W    = 24;  // angle and mean width
  localparam int COUNT_WIDTH = 32;  // sample counter width
  localparam int FRAC_BITS   = 8;   // fraction bits of angles
  localparam int VAR_W       = 40;  // variance width
  localparam int STD_W       = 24;  // standard deviation width
  localparam int DIFF_W      = SAMPLE_W + 1;        // x - mean
  localparam int PROD_W      = 2 * DIFF_W;          // square of a difference
  localparam int RAD_W       = VAR_W + FRAC_BITS;   // square root radicand
  localparam int OUT_DATA_W  = COUNT_WIDTH + SAMPLE_W + VAR_W + STD_W;

  localparam logic [7:0] CFG_STATS_ENABLE  = 8'd0;
  localparam logic [7:0] CFG_TRIGGER_ANGLE = 8'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_STEP,
    ST_MUL_STEP_SQ,
    ST_DIV_VAR,
    ST_MUL_ERR_SQ,
    ST_DIV_ERR,
    ST_SQRT,
    ST_FIN
  } state_t;

endpackage

/* rtl/running_mean_variance_stats_unit.sv */
// ----------------------------------------------------------------------------
// running_mean_variance_stats_unit: running mean, variance and deviation
// Bit-serial divider, multiplier and square root under one sequencer.
// ----------------------------------------------------------------------------
// Timing: an item that is not accumulated has its result valid from the cycle
// after acceptance; an accumulated item runs the serial steps divide, multiply,
// divide, multiply, divide and square root, then a result state (the first one
// only divides). Accumulated items are taken one at a time by the shared radix-2
// serial units; others can follow every cycle while the output slot is free.
// Reset (rst_n low, synchronous) clears the statistics and arming and loads
// stats_enable = 1, trigger_angle = 180.
module running_mean_variance_stats_unit
  import rmvs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [SAMPLE_W-1:0]   in_tdata,   // [23:0] angle_sample
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // count, mean, variance, std_deviation
  output logic                  out_tuser,  // [0] stats_valid
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [7:0]            cfg_index,
  input  logic [15:0]           cfg_data
);

  state_t state_r, state_nxt;

  logic                          enable_r;
  logic signed [15:0]            trig_r;
  logic                          armed_r;
  logic [COUNT_WIDTH-1:0]        count_r;
  logic signed [SAMPLE_W-1:0]    mean_r;
  logic [VAR_W-1:0]              var_r;
  logic [STD_W-1:0]              std_r;
  logic signed [SAMPLE_W-1:0]    x_r;
  logic                          dneg_r;
  logic [5:0]                    cnt_r;
  logic [PROD_W-3:0]             s2_r;
  logic [VAR_W-1:0]              acc_r;

  // serial divider
  logic [PROD_W-1:0]             dq_r;
  logic [COUNT_WIDTH-1:0]        drem_r;
  logic [COUNT_WIDTH-1:0]        dv_r;
  // serial multiplier
  logic [DIFF_W-1:0]             ma_r, mhi_r, mlo_r;
  // serial square root
  logic [RAD_W-1:0]              rad_r;
  logic [STD_W+1:0]              srem_r;
  logic [STD_W-1:0]              root_r;

  logic                          out_valid_r;
  logic                          out_user_r;
  logic [OUT_DATA_W-1:0]         out_data_r;

  logic accept, last, slot_free, out_load;

  // arm check: sample truncated toward zero to whole degrees
  logic signed [SAMPLE_W-FRAC_BITS-1:0] x_whole;
  logic                                 trig_hit, accum;
  logic signed [SAMPLE_W-1:0]           x_in;
  logic [COUNT_WIDTH-1:0]               cnt_inc;
  logic signed [DIFF_W-1:0]             d_in, e_val;
  logic [DIFF_W-1:0]                    d_mag, e_mag;

  assign x_in    = signed'(in_tdata);
  assign x_whole = x_in[SAMPLE_W-1:FRAC_BITS]
                   + ((x_in[SAMPLE_W-1] && (x_in[FRAC_BITS-1:0] != '0)) ? 16'sd1 : 16'sd0);
  assign trig_hit = (x_whole == trig_r);
  assign accum    = (armed_r || trig_hit) && enable_r;
  assign cnt_inc  = (count_r == '1) ? count_r : count_r + 1'b1;
  assign d_in     = {x_in[SAMPLE_W-1], x_in} - {mean_r[SAMPLE_W-1], mean_r};
  assign d_mag    = d_in[DIFF_W-1] ? DIFF_W'(-d_in) : DIFF_W'(d_in);
  assign e_val    = {x_r[SAMPLE_W-1], x_r} - {mean_r[SAMPLE_W-1], mean_r};
  assign e_mag    = e_val[DIFF_W-1] ? DIFF_W'(-e_val) : DIFF_W'(e_val);

  // one restoring division step
  logic [COUNT_WIDTH:0]   div_t;
  logic                   div_ge;
  logic [COUNT_WIDTH-1:0] div_rem;
  logic [PROD_W-1:0]      div_q;
  assign div_t   = {drem_r, dq_r[PROD_W-1]};
  assign div_ge  = div_t >= {1'b0, dv_r};
  assign div_rem = div_ge ? COUNT_WIDTH'(div_t - {1'b0, dv_r}) : div_t[COUNT_WIDTH-1:0];
  assign div_q   = {dq_r[PROD_W-2:0], div_ge};

  // one shift-add multiplication step
  logic [DIFF_W:0]   mul_t;
  logic [DIFF_W-1:0] mul_hi, mul_lo;
  assign mul_t  = {1'b0, mhi_r} + (mlo_r[0] ? {1'b0, ma_r} : '0);
  assign mul_hi = mul_t[DIFF_W:1];
  assign mul_lo = {mul_t[0], mlo_r[DIFF_W-1:1]};

  // one digit of the square root
  logic [STD_W+3:0] sq_t, sq_trial;
  logic             sq_ge;
  logic [STD_W+1:0] sq_rem;
  logic [STD_W-1:0] sq_root;
  assign sq_t     = {srem_r, rad_r[RAD_W-1:RAD_W-2]};
  assign sq_trial = {2'b00, root_r, 2'b01};
  assign sq_ge    = sq_t >= sq_trial;
  assign sq_rem   = sq_ge ? (STD_W+2)'(sq_t - sq_trial) : sq_t[STD_W+1:0];
  assign sq_root  = {root_r[STD_W-2:0], sq_ge};

  // final variance combination
  logic signed [DIFF_W-1:0] step_val;
  logic [PROD_W:0]          tail_sum;
  logic [VAR_W+3:0]         var_tot;
  logic [VAR_W-1:0]         var_new;
  assign step_val = dneg_r ? DIFF_W'(-div_q[DIFF_W-1:0]) : DIFF_W'(div_q[DIFF_W-1:0]);
  assign tail_sum = {3'b000, s2_r} + {1'b0, div_q};
  assign var_tot  = {4'b0000, acc_r} + (VAR_W+4)'(tail_sum >> FRAC_BITS);
  assign var_new  = (var_tot[VAR_W+3:VAR_W] != '0) ? '1 : var_tot[VAR_W-1:0];

  // next-state logic
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:        if (accept && accum) state_nxt = ST_DIV_STEP;
      ST_DIV_STEP:    if (last) state_nxt = (count_r == 1) ? ST_FIN : ST_MUL_STEP_SQ;
      ST_MUL_STEP_SQ: if (last) state_nxt = ST_DIV_VAR;
      ST_DIV_VAR:     if (last) state_nxt = ST_MUL_ERR_SQ;
      ST_MUL_ERR_SQ:  if (last) state_nxt = ST_DIV_ERR;
      ST_DIV_ERR:     if (last) state_nxt = ST_SQRT;
      ST_SQRT:        if (last) state_nxt = ST_FIN;
      ST_FIN:         if (slot_free) state_nxt = ST_IDLE;
      default:        state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    slot_free = !out_valid_r || out_tready;
    last      = (cnt_r == 6'd1);
    in_tready = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: in_tready = slot_free;
      ST_FIN:  out_load  = slot_free;
      default: begin
        in_tready = 1'b0;
        out_load  = 1'b0;
      end
    endcase
    accept = in_tvalid && in_tready;
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_user_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      enable_r    <= 1'b1;
      trig_r      <= 16'sd180;
      armed_r     <= 1'b0;
      count_r     <= '0;
      mean_r      <= '0;
      var_r       <= '0;
      std_r       <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        if (cfg_index == CFG_STATS_ENABLE) enable_r <= cfg_data[0];
        else if (cfg_index == CFG_TRIGGER_ANGLE) trig_r <= signed'(cfg_data);
      end
      if (out_tvalid && out_tready) out_valid_r <= 1'b0;
      if (state_r != ST_IDLE && state_r != ST_FIN) cnt_r <= cnt_r - 1'b1;

      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            x_r <= x_in;
            if (trig_hit) armed_r <= 1'b1;
            if (accum) begin
              count_r <= cnt_inc;
              dv_r    <= cnt_inc;
              dq_r    <= {d_mag, {(PROD_W-DIFF_W){1'b0}}};
              drem_r  <= '0;
              dneg_r  <= d_in[DIFF_W-1];
              cnt_r   <= 6'(DIFF_W);
            end else begin
              out_valid_r <= 1'b1;
              out_user_r  <= 1'b0;
              out_data_r  <= {std_r, var_r, mean_r, count_r};
            end
          end
        end
        ST_DIV_STEP: begin
          dq_r   <= div_q;
          drem_r <= div_rem;
          if (last) begin
            mean_r <= SAMPLE_W'({mean_r[SAMPLE_W-1], mean_r} + step_val);
            if (count_r == 1) begin
              var_r <= '0;
              std_r <= '0;
            end else begin
              ma_r  <= div_q[DIFF_W-1:0];
              mlo_r <= div_q[DIFF_W-1:0];
              mhi_r <= '0;
              cnt_r <= 6'(DIFF_W);
            end
          end
        end
        ST_MUL_STEP_SQ: begin
          mhi_r <= mul_hi;
          mlo_r <= mul_lo;
          if (last) begin
            s2_r   <= (PROD_W-2)'({mul_hi, mul_lo});
            dq_r   <= {var_r, {(PROD_W-VAR_W){1'b0}}};
            drem_r <= '0;
            dv_r   <= count_r - 1'b1;
            cnt_r  <= 6'(VAR_W);
          end
        end
        ST_DIV_VAR: begin
          dq_r   <= div_q;
          drem_r <= div_rem;
          if (last) begin
            acc_r <= var_r - div_q[VAR_W-1:0];
            ma_r  <= e_mag;
            mlo_r <= e_mag;
            mhi_r <= '0;
            cnt_r <= 6'(DIFF_W);
          end
        end
        ST_MUL_ERR_SQ: begin
          mhi_r <= mul_hi;
          mlo_r <= mul_lo;
          if (last) begin
            dq_r   <= {mul_hi, mul_lo};
            drem_r <= '0;
            cnt_r  <= 6'(PROD_W);
          end
        end
        ST_DIV_ERR: begin
          dq_r   <= div_q;
          drem_r <= div_rem;
          if (last) begin
            var_r  <= var_new;
            rad_r  <= {var_new, {FRAC_BITS{1'b0}}};
            srem_r <= '0;
            root_r <= '0;
            cnt_r  <= 6'(STD_W);
          end
        end
        ST_SQRT: begin
          rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
          srem_r <= sq_rem;
          root_r <= sq_root;
          if (last) std_r <= sq_root;
        end
        ST_FIN: begin
          if (out_load) begin
            out_valid_r <= 1'b1;
            out_user_r  <= 1'b1;
            out_data_r  <= {std_r, var_r, mean_r, count_r};
          end
        end
        default: begin
          cnt_r <= '0;
        end
      endcase
    end
  end

  // A sample count of one or less always goes with a zero variance.
  a_var_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= 1) |-> (var_r == '0))
    else $error("variance nonzero with fewer than two samples");

  // Once armed, the unit stays armed until reset.
  a_armed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    armed_r |=> armed_r)
    else $error("arming was lost");

  // An accumulated result always reports at least one sample.
  a_count_on_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[COUNT_WIDTH-1:0] != '0))
    else $error("accumulated item reported with zero count");

  // The square root finishes straight into the result stage.
  a_sqrt_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SQRT && cnt_r == 6'd1) |=> (state_r == ST_FIN))
    else $error("square root did not hand over to the result stage");

endmodule
